[rtl/bubble_sort_engine_unit_assert.svh]
// ----------------------------------------------------------------------------
// bubble sort engine assertion macros
// Shorthand for clocked port assertions, with reset masking.
// ----------------------------------------------------------------------------
`ifndef BUBBLE_SORT_ENGINE_UNIT_ASSERT_SVH
`define BUBBLE_SORT_ENGINE_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define BSE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/bse_pkg.sv]
// ----------------------------------------------------------------------------
// bse_pkg
// Shared types and fixed widths of the bubble sort engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bse_pkg;

  localparam int DATA_W = 32;
  localparam int SWAP_W = 9;
  localparam logic [SWAP_W-1:0] SWAP_MAX = '1;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD0,
    ST_LD0,
    ST_CMP,
    ST_PEND,
    ST_EMIT,
    ST_DRAIN
  } bse_state_t;

  // result issue control, asserted in the cycle before the result strobe
  typedef struct packed {
    logic issue;
    logic last;
  } bse_emit_t;

endpackage

[rtl/bse_mem.sv]
// ----------------------------------------------------------------------------
// bse_mem
// Element store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bse_mem
  import bse_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int ADDR_W = 5
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] store [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= store[raddr];
    end
  end

endmodule

[rtl/bse_ctrl.sv]
// ----------------------------------------------------------------------------
// bse_ctrl
// Load, sort-pass and emit sequencer; carries the bubbling element between
// memory reads and counts swaps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bse_ctrl
  import bse_pkg::*;
#(
  parameter int MAX_ELEMENTS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [DATA_W-1:0]                 value,
  input  logic                              last_in,
  output logic                              busy,
  output logic                              mem_we,
  output logic [$clog2(MAX_ELEMENTS)-1:0]   mem_waddr,
  output logic [DATA_W-1:0]                 mem_wdata,
  output logic                              mem_re,
  output logic [$clog2(MAX_ELEMENTS)-1:0]   mem_raddr,
  input  logic [DATA_W-1:0]                 mem_rdata,
  output bse_emit_t                         emit,
  output logic [SWAP_W-1:0]                 swap_total,
  output logic                              overflow
);

  localparam int IDX_W = $clog2(MAX_ELEMENTS);
  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

  bse_state_t        state;
  bse_state_t        state_next;
  logic [CNT_W-1:0]  count;
  logic [IDX_W-1:0]  idx;
  logic [DATA_W-1:0] held;
  logic              pass_swapped;
  logic [SWAP_W-1:0] swap_cnt;
  logic              ovf;

  logic              accept;
  logic              full;
  logic [CNT_W-1:0]  count_after;
  logic [CNT_W-1:0]  last_pos;
  logic              cmp_gt;
  logic              cmp_at_end;
  logic              emit_at_end;

  // status terms
  assign accept      = start && (state == ST_IDLE);
  assign full        = (count == CNT_W'(MAX_ELEMENTS));
  assign count_after = full ? count : count + CNT_W'(1);
  assign last_pos    = count - CNT_W'(1);
  assign cmp_gt      = $signed(held) > $signed(mem_rdata);
  assign cmp_at_end  = (CNT_W'(idx) + CNT_W'(1)) == last_pos;
  assign emit_at_end = CNT_W'(idx) == last_pos;

  assign busy       = (state != ST_IDLE);
  assign swap_total = swap_cnt;
  assign overflow   = ovf;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && last_in) begin
          state_next = (count_after >= CNT_W'(2)) ? ST_RD0 : ST_EMIT;
        end
      end
      ST_RD0:  state_next = ST_LD0;
      ST_LD0:  state_next = ST_CMP;
      ST_CMP: begin
        if (cmp_at_end) begin
          state_next = ST_PEND;
        end
      end
      ST_PEND: state_next = pass_swapped ? ST_LD0 : ST_EMIT;
      ST_EMIT: begin
        if (emit_at_end) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // memory accesses and result issue
  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = idx;
    mem_wdata  = held;
    mem_re     = 1'b0;
    mem_raddr  = idx;
    emit.issue = 1'b0;
    emit.last  = 1'b0;
    case (state)
      ST_IDLE: begin
        mem_we    = accept && !full;
        mem_waddr = count[IDX_W-1:0];
        mem_wdata = value;
      end
      ST_RD0: begin
        mem_re    = 1'b1;
        mem_raddr = '0;
      end
      ST_LD0: begin
        mem_re    = 1'b1;
        mem_raddr = IDX_W'(1);
      end
      ST_CMP: begin
        // the smaller of the pair settles at idx, the larger keeps bubbling
        mem_we    = 1'b1;
        mem_waddr = idx;
        mem_wdata = cmp_gt ? mem_rdata : held;
        mem_re    = !cmp_at_end;
        mem_raddr = idx + IDX_W'(2);
      end
      ST_PEND: begin
        // park the pass maximum at the top, prefetch entry zero
        mem_we    = 1'b1;
        mem_waddr = last_pos[IDX_W-1:0];
        mem_wdata = held;
        mem_re    = 1'b1;
        mem_raddr = '0;
      end
      ST_EMIT: begin
        mem_re     = 1'b1;
        mem_raddr  = idx;
        emit.issue = 1'b1;
        emit.last  = emit_at_end;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      idx          <= '0;
      pass_swapped <= 1'b0;
      swap_cnt     <= '0;
      ovf          <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            idx <= '0;
            if (full) begin
              ovf <= 1'b1;
            end else begin
              count <= count + CNT_W'(1);
            end
          end
        end
        ST_RD0: begin
          pass_swapped <= 1'b0;
          idx          <= '0;
        end
        ST_CMP: begin
          if (cmp_gt) begin
            pass_swapped <= 1'b1;
            if (swap_cnt != SWAP_MAX) begin
              swap_cnt <= swap_cnt + SWAP_W'(1);
            end
          end
          if (!cmp_at_end) begin
            idx <= idx + IDX_W'(1);
          end
        end
        ST_PEND: begin
          pass_swapped <= 1'b0;
          idx          <= '0;
        end
        ST_EMIT: begin
          if (!emit_at_end) begin
            idx <= idx + IDX_W'(1);
          end
        end
        ST_DRAIN: begin
          count    <= '0;
          swap_cnt <= '0;
          ovf      <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // bubbling element
  always_ff @(posedge clk) begin
    if (state == ST_LD0) begin
      held <= mem_rdata;
    end else if (state == ST_CMP && !cmp_gt) begin
      held <= mem_rdata;
    end
  end

endmodule

[rtl/bubble_sort_engine_unit.sv]
// Each item is stored as it is taken, so the next item can follow at once; busy stays low between items of a set.
// After the last item of a set of n values, busy goes high for P sort passes
// (P <= n), the last of which makes no swap, then the emit phase; n = 1 skips the passes.
// The sort is bound by the single read and write port of the element store.
// Results come one per cycle once the emit phase has begun, the strobe registered from the read issue.
// Synchronous reset empties the set and clears counts; store contents are kept.
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// bubble_sort_engine_unit
// Collects signed values, sorts them ascending by adjacent compare-and-swap
// passes in an on-chip store, and streams the sorted set with its swap count.
// ----------------------------------------------------------------------------
module bubble_sort_engine_unit
  import bse_pkg::*;
#(
  parameter int MAX_ELEMENTS = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [31:0]       value,
  input  logic                     last_in,
  output logic                     result_valid,
  output logic signed [31:0]       sorted_value,
  output logic                     last_out,
  output logic [8:0]               swap_total,
  output logic                     overflow
);

  localparam int IDX_W = $clog2(MAX_ELEMENTS);

  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [IDX_W-1:0]  mem_raddr;
  logic [DATA_W-1:0] mem_rdata;
  bse_emit_t         emit;

  // element store
  bse_mem #(
    .DEPTH  (MAX_ELEMENTS),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // sequencer
  bse_ctrl #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .value      (value),
    .last_in    (last_in),
    .busy       (busy),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata),
    .emit       (emit),
    .swap_total (swap_total),
    .overflow   (overflow)
  );

  // result strobe lines up with the registered read data
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= emit.issue;
    end
  end

  always_ff @(posedge clk) begin
    last_out <= emit.last;
  end

  assign sorted_value = mem_rdata;

endmodule

[rtl/bse_checker.sv]
// ----------------------------------------------------------------------------
// bse_checker
// Port-level checks of the bubble sort engine result sequencing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "bubble_sort_engine_unit_assert.svh"

module bse_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       last_in,
  input logic       result_valid,
  input logic       last_out,
  input logic [8:0] swap_total
);

  // results only appear while a set is being processed
  `BSE_ASSERT_SAME(a_result_in_busy, result_valid, busy, "result outside busy window")

  // a set streams without gaps and with one swap count
  `BSE_ASSERT_NEXT(a_stream_contig, result_valid && !last_out, result_valid && $stable(swap_total), "gap or count change inside a set")

  // the final item of a set is followed by idle
  `BSE_ASSERT_NEXT(a_last_ends, result_valid && last_out, !result_valid && !busy, "activity after final item")

  // busy stays low after an item without the last mark
  `BSE_ASSERT_NEXT(a_load_quick, start && !busy && !last_in, !busy, "load item stalled the engine")

  // a marked item starts processing
  `BSE_ASSERT_NEXT(a_last_starts, start && !busy && last_in, busy, "last item did not start sort")

endmodule

bind bubble_sort_engine_unit bse_checker u_bse_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .last_in      (last_in),
  .result_valid (result_valid),
  .last_out     (last_out),
  .swap_total   (swap_total)
);
